@@ rtl/core/prast_pkg.sv @@
package prast_pkg;

  localparam int CB_DEFAULT   = 16;
  localparam int MODE_BITS    = 2;
  localparam int FA_BITS      = 12;
  localparam int DIM_BITS     = 13;
  localparam int OFFX_BITS    = 13;
  localparam int DEC_BITS     = 20;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_UP   = 2'd0,
    MODE_DOWN = 2'd1,
    MODE_MID  = 2'd2,
    MODE_STEP = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_REG1 = 2'd1,
    PH_REG2 = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic finished;
    logic drawn;
  } flags_t;

endpackage

@@ rtl/core/prast_walk.sv @@
module prast_walk
  import prast_pkg::*;
#(
  parameter int COORD_BITS = CB_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  mode_t                        mode,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic [FA_BITS-1:0]           focal_a,
  input  logic [DIM_BITS-1:0]          screen_width,
  input  logic [DIM_BITS-1:0]          screen_height,
  output logic [COORD_BITS:0]          right_x,
  output logic [COORD_BITS:0]          left_x,
  output logic [COORD_BITS:0]          point_y,
  output flags_t                       flags
);

  localparam int YB = (COORD_BITS + 1 > 14) ? COORD_BITS + 1 : 14;
  localparam int SW = (COORD_BITS + 1 > OFFX_BITS + 1) ? COORD_BITS + 1 : OFFX_BITS + 1;
  localparam int DB = DEC_BITS;
  localparam logic signed [YB-1:0] Y_MIN = {{(YB-COORD_BITS){1'b1}}, {COORD_BITS{1'b0}}};
  localparam logic signed [YB-1:0] Y_ONE = YB'(1);
  localparam logic signed [DB-1:0] D_ONE = DB'(1);
  localparam logic signed [DB-1:0] D_THREE = DB'(3);
  localparam logic signed [DB-1:0] D_FOUR = DB'(4);

  phase_t                       phase, phase_next;
  mode_t                        kind, kind_next;
  logic signed [COORD_BITS-1:0] vertex_x, vertex_x_next;
  logic signed [COORD_BITS-1:0] vertex_y, vertex_y_next;
  logic [FA_BITS-1:0]           param_a, param_a_next;
  logic [OFFX_BITS-1:0]         offset_x, offset_x_next;
  logic signed [YB-1:0]         offset_y, offset_y_next;
  logic signed [DB-1:0]         decision, decision_next;
  logic                         drawn;

  logic signed [DB-1:0] a_d, x_d, bx_d, t_d, bres_d, mid_d, base_d, r2_d;
  logic signed [DB-1:0] fa_d;
  logic                 d_le0, b_le0, x_lt_a, r1_end, is_down, r2_go;
  logic [OFFX_BITS-1:0] base_x, r2_x;
  logic signed [YB-1:0] base_y, r2_y, y_step;
  logic [SW-1:0]        vx_ext, ox_ext, sum_r, sum_l;
  logic [YB-1:0]        vy_ext, sum_y;

  // region 1 arithmetic
  assign a_d    = signed'(DB'(param_a));
  assign x_d    = signed'(DB'(offset_x));
  assign t_d    = (x_d <<< 1) + D_THREE;
  assign d_le0  = decision[DB-1] | (decision == '0);
  assign x_lt_a = offset_x < OFFX_BITS'(param_a);
  assign is_down = (kind == MODE_DOWN);
  assign y_step = is_down ? offset_y - Y_ONE : offset_y + Y_ONE;
  assign bres_d = d_le0 ? decision + t_d : decision + t_d - (a_d <<< 1);
  assign mid_d  = d_le0 ? decision + (a_d <<< 1) - t_d : decision - t_d;

  // region 2 starts from reloaded values when region 1 has just ended
  assign r1_end = (phase == PH_REG1);
  assign base_d = r1_end ? (a_d <<< 1) - D_ONE : decision;
  assign base_x = (r1_end && is_down) ? OFFX_BITS'(param_a) : offset_x;
  assign base_y = (r1_end && is_down) ? -signed'(YB'(param_a >> 1)) : offset_y;
  assign bx_d   = signed'(DB'(base_x));
  assign fa_d   = a_d <<< 2;
  assign b_le0  = base_d[DB-1] | (base_d == '0);
  assign r2_d   = b_le0 ? base_d + fa_d : base_d + fa_d - (bx_d <<< 2) - D_FOUR;
  assign r2_x   = b_le0 ? base_x : base_x + OFFX_BITS'(1);
  assign r2_y   = is_down ? base_y - Y_ONE : base_y + Y_ONE;
  assign r2_go  = (base_x < screen_width) &&
                  (is_down ? (base_y > Y_MIN)
                           : (base_y < signed'(YB'(screen_height))));

  always_comb begin
    phase_next    = phase;
    kind_next     = kind;
    vertex_x_next = vertex_x;
    vertex_y_next = vertex_y;
    param_a_next  = param_a;
    offset_x_next = offset_x;
    offset_y_next = offset_y;
    decision_next = decision;
    drawn         = 1'b0;
    if (mode != MODE_STEP) begin
      phase_next    = PH_REG1;
      kind_next     = mode;
      vertex_x_next = center_x;
      vertex_y_next = center_y;
      param_a_next  = focal_a;
      offset_x_next = '0;
      offset_y_next = '0;
      decision_next = (mode == MODE_MID) ? signed'(DB'(focal_a)) - D_ONE
                                         : D_ONE - signed'(DB'(focal_a));
      drawn         = 1'b1;
    end else begin
      case (phase)
        PH_REG1: begin
          if (x_lt_a) begin
            offset_x_next = offset_x + OFFX_BITS'(1);
            drawn         = 1'b1;
            if (kind == MODE_MID) begin
              decision_next = mid_d;
              if (d_le0) begin
                offset_y_next = offset_y + Y_ONE;
              end
            end else begin
              decision_next = bres_d;
              if (!d_le0) begin
                offset_y_next = y_step;
              end
            end
          end else if (kind == MODE_MID) begin
            phase_next = PH_DONE;
          end else if (r2_go) begin
            phase_next    = PH_REG2;
            offset_x_next = r2_x;
            offset_y_next = r2_y;
            decision_next = r2_d;
            drawn         = 1'b1;
          end else begin
            phase_next = PH_DONE;
          end
        end
        PH_REG2: begin
          if (r2_go) begin
            offset_x_next = r2_x;
            offset_y_next = r2_y;
            decision_next = r2_d;
            drawn         = 1'b1;
          end else begin
            phase_next = PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // point pair from the updated walk position
  assign vx_ext = {{(SW-COORD_BITS){vertex_x_next[COORD_BITS-1]}}, vertex_x_next};
  assign ox_ext = SW'(offset_x_next);
  assign sum_r  = vx_ext + ox_ext;
  assign sum_l  = vx_ext - ox_ext;
  assign vy_ext = {{(YB-COORD_BITS){vertex_y_next[COORD_BITS-1]}}, vertex_y_next};
  assign sum_y  = vy_ext + offset_y_next;

  assign right_x        = drawn ? sum_r[COORD_BITS:0] : '0;
  assign left_x         = drawn ? sum_l[COORD_BITS:0] : '0;
  assign point_y        = drawn ? sum_y[COORD_BITS:0] : '0;
  assign flags.drawn    = drawn;
  assign flags.finished = !drawn;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      kind     <= MODE_UP;
      vertex_x <= '0;
      vertex_y <= '0;
      param_a  <= '0;
      offset_x <= '0;
      offset_y <= '0;
      decision <= '0;
    end else if (load) begin
      phase    <= phase_next;
      kind     <= kind_next;
      vertex_x <= vertex_x_next;
      vertex_y <= vertex_y_next;
      param_a  <= param_a_next;
      offset_x <= offset_x_next;
      offset_y <= offset_y_next;
      decision <= decision_next;
    end
  end

  a_start_enters_reg1: assert property (@(posedge clk) disable iff (rst)
    (load && mode != MODE_STEP) |=> (phase == PH_REG1))
    else $error("start beat did not enter region 1");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE && !(load && mode != MODE_STEP)) |=> (phase == PH_DONE))
    else $error("ended walk left done without a start");

  a_idle_step_quiet: assert property (@(posedge clk) disable iff (rst)
    (load && mode == MODE_STEP && (phase == PH_IDLE || phase == PH_DONE))
      |-> (!flags.drawn ##1 phase == $past(phase)))
    else $error("step outside a walk drew or moved");

endmodule

@@ rtl/core/prast_obuf.sv @@
module prast_obuf
  import prast_pkg::*;
#(
  parameter int DATA_BITS = 56
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DATA_BITS-1:0] in_data,
  input  flags_t               in_flags,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_BITS-1:0] out_data,
  output flags_t               out_flags
);

  logic load;

  // slot is free when empty or being drained this cycle
  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data  <= in_data;
      out_flags <= in_flags;
    end
  end

endmodule

@@ rtl/core/parabola_rasterizer_unit.sv @@
// Parabola rasterizer: walks a vertical-axis parabola with integer decision
// variables and returns at most one mirrored point pair per input beat.
// Input channel s_*: s_tuser carries the beat kind (start up, start down,
// start midpoint, step); s_tdata carries vertex x, vertex y and A, read on
// start beats only. Every input beat yields exactly one output beat.
// Output channel m_*: m_tdata holds right x, left x and the shared row;
// m_tuser flags whether a pair was drawn or the curve is finished.
// The output beat appears in the cycle after its input beat is taken, and
// one beat is taken every cycle while m_tready is high; the walk state and
// the result register are updated together at the input handshake, so
// throughput is set by that single register stage.
// When m_tready is low the result stays in the output register and the
// input stays open until that register is full; a new beat is then taken
// in the same cycle the held result leaves.
// The user must write screen width and height via cfg_we/cfg_index/cfg_data
// only while the channel is idle; the block does not enforce this. Reset
// empties the output register, idles the walk, sets width 640, height 480.
module parabola_rasterizer_unit
  import prast_pkg::*;
#(
  parameter int COORD_BITS = CB_DEFAULT
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  // center_x, center_y, focal_a
  input  logic [((2*COORD_BITS+FA_BITS+7)/8)*8-1:0]  s_tdata,
  // mode
  input  logic [MODE_BITS-1:0]                       s_tuser,
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  // right_x, left_x, point_y
  output logic [((3*(COORD_BITS+1)+7)/8)*8-1:0]      m_tdata,
  // drawn, finished
  output logic [1:0]                                 m_tuser,
  input  logic                                       cfg_we,
  input  logic                                       cfg_index,
  input  logic [DIM_BITS-1:0]                        cfg_data
);

  localparam int OUT_W = ((3*(COORD_BITS+1)+7)/8)*8;

  logic [DIM_BITS-1:0]   screen_width, screen_height;
  logic                  load;
  logic [COORD_BITS:0]   right_x, left_x, point_y;
  flags_t                flags, out_flags;
  logic [OUT_W-1:0]      res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= DIM_BITS'(WIDTH_RESET);
      screen_height <= DIM_BITS'(HEIGHT_RESET);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  screen_width  <= cfg_data;
        REG_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign load = s_tvalid && s_tready;

  prast_walk #(
    .COORD_BITS(COORD_BITS)
  ) u_walk (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .mode          (mode_t'(s_tuser)),
    .center_x      (signed'(s_tdata[COORD_BITS-1:0])),
    .center_y      (signed'(s_tdata[2*COORD_BITS-1:COORD_BITS])),
    .focal_a       (s_tdata[2*COORD_BITS+FA_BITS-1:2*COORD_BITS]),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .right_x       (right_x),
    .left_x        (left_x),
    .point_y       (point_y),
    .flags         (flags)
  );

  assign res_data = OUT_W'({point_y, left_x, right_x});

  prast_obuf #(
    .DATA_BITS(OUT_W)
  ) u_obuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (res_data),
    .in_flags  (flags),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_flags (out_flags)
  );

  assign m_tuser = out_flags;

  a_beat_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted beat left no result");

  a_start_draws_vertex: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && mode_t'(s_tuser) != MODE_STEP)
      |=> (m_tuser[0] && !m_tuser[1] &&
           m_tdata[COORD_BITS:0] == m_tdata[2*COORD_BITS+1:COORD_BITS+1]))
    else $error("start beat did not return the vertex");

endmodule

@@ verif/parabola_rasterizer_unit_tb.sv @@
`timescale 1ns / 100ps

module parabola_rasterizer_unit_tb;
  import prast_pkg::*;

  localparam int CB = CB_DEFAULT;
  localparam int IN_W = ((2*CB+FA_BITS+7)/8)*8;
  localparam int OUT_W = ((3*(CB+1)+7)/8)*8;
  localparam longint DOWN_FLOOR = -(64'sd1 << CB);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PRINT_CAP = 50;

  typedef struct packed {
    mode_t mode;
    logic [CB-1:0] cx;
    logic [CB-1:0] cy;
    logic [FA_BITS-1:0] a;
  } rast_beat_t;

  typedef struct packed {
    logic [CB:0] right_x;
    logic [CB:0] left_x;
    logic [CB:0] point_y;
    logic drawn;
    logic finished;
  } walk_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [MODE_BITS-1:0] s_tuser = MODE_STEP;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_WIDTH;
  logic [DIM_BITS-1:0] cfg_data = '0;

  parabola_rasterizer_unit #(
    .COORD_BITS(CB)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  phase_t walk_phase = PH_IDLE;
  mode_t walk_kind = MODE_UP;
  longint vx = 0, vy = 0, pa = 0, ox = 0, oy = 0, dec = 0;
  longint width_reg = WIDTH_RESET;
  longint height_reg = HEIGHT_RESET;

  rast_beat_t pending_beats[$];
  walk_point_t expected_points[$];
  rast_beat_t offered;
  logic beat_taken = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  int error_count = 0;
  int beats_queued = 0;
  int starts_queued = 0;
  int points_checked = 0;
  int pairs_seen = 0;
  int ends_seen = 0;
  int cycle_count = 0;

  function automatic walk_point_t pair_at(input bit drawn);
    walk_point_t p;
    p = '0;
    if (drawn) begin
      p.right_x = (CB+1)'(vx + ox);
      p.left_x = (CB+1)'(vx - ox);
      p.point_y = (CB+1)'(vy + oy);
      p.drawn = 1'b1;
    end else begin
      p.finished = 1'b1;
    end
    return p;
  endfunction

  function automatic bit region2_advance();
    bit go;
    if (walk_kind == MODE_DOWN)
      go = (ox < width_reg) && (oy > DOWN_FLOOR);
    else
      go = (ox < width_reg) && (oy < height_reg);
    if (!go)
      return 1'b0;
    if (dec <= 0) begin
      dec += 4 * pa;
    end else begin
      dec += 4 * pa - 4 * ox - 4;
      ox++;
    end
    oy += (walk_kind == MODE_DOWN) ? -1 : 1;
    return 1'b1;
  endfunction

  function automatic walk_point_t next_point(input rast_beat_t b);
    if (b.mode != MODE_STEP) begin
      walk_kind = b.mode;
      vx = $signed(b.cx);
      vy = $signed(b.cy);
      pa = b.a;
      ox = 0;
      oy = 0;
      dec = (b.mode == MODE_MID) ? pa - 1 : 1 - pa;
      walk_phase = PH_REG1;
      return pair_at(1'b1);
    end
    if (walk_phase == PH_REG1) begin
      if (ox < pa) begin
        if (walk_kind == MODE_MID) begin
          if (dec <= 0) begin
            dec += 2 * pa - 2 * ox - 3;
            oy++;
          end else begin
            dec += -2 * ox - 3;
          end
        end else if (dec <= 0) begin
          dec += 2 * ox + 3;
        end else begin
          dec += 2 * ox + 3 - 2 * pa;
          oy += (walk_kind == MODE_DOWN) ? -1 : 1;
        end
        ox++;
        return pair_at(1'b1);
      end
      if (walk_kind == MODE_MID) begin
        walk_phase = PH_DONE;
        return pair_at(1'b0);
      end
      // region 1 over, fall straight into region 2
      dec = 2 * pa - 1;
      if (walk_kind == MODE_DOWN) begin
        ox = pa;
        oy = -(pa / 2);
      end
      walk_phase = PH_REG2;
    end
    if (walk_phase == PH_REG2) begin
      if (region2_advance())
        return pair_at(1'b1);
      walk_phase = PH_DONE;
    end
    return pair_at(1'b0);
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    if (error_count < PRINT_CAP)
      $display("[%0t] %s: expected %0d, got %0d (point %0d)", $time, what, want, got,
               points_checked);
    error_count++;
  endtask

  // sender
  always @(negedge clk) begin
    if (!s_tvalid || beat_taken) begin
      if (!rst && pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered = pending_beats.pop_front();
        s_tdata <= IN_W'({offered.a, offered.cy, offered.cx});
        s_tuser <= offered.mode;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_tready <= 1'b0;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor and checker
  always @(posedge clk) begin : monitor
    walk_point_t got, want;
    beat_taken <= s_tvalid && s_tready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.right_x = m_tdata[CB:0];
        got.left_x = m_tdata[2*CB+1:CB+1];
        got.point_y = m_tdata[3*CB+2:2*CB+2];
        got.drawn = m_tuser[0];
        got.finished = m_tuser[1];
        if (got.drawn)
          pairs_seen++;
        if (got.finished)
          ends_seen++;
        if (expected_points.size() == 0) begin
          report_mismatch("output beat with nothing pending", 0, 1);
        end else begin
          want = expected_points.pop_front();
          if (got.right_x !== want.right_x)
            report_mismatch("right_x", $signed(want.right_x), $signed(got.right_x));
          if (got.left_x !== want.left_x)
            report_mismatch("left_x", $signed(want.left_x), $signed(got.left_x));
          if (got.point_y !== want.point_y)
            report_mismatch("point_y", $signed(want.point_y), $signed(got.point_y));
          if (got.drawn !== want.drawn)
            report_mismatch("drawn", want.drawn, got.drawn);
          if (got.finished !== want.finished)
            report_mismatch("finished", want.finished, got.finished);
        end
        points_checked++;
      end
      if (s_tvalid && s_tready)
        expected_points.push_back(next_point(offered));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d points outstanding", cycle_count,
               expected_points.size());
      $display("parabola_rasterizer_unit_tb: errors");
      $finish;
    end
  end

  task automatic queue_beat(input mode_t m, input logic [CB-1:0] cx, input logic [CB-1:0] cy,
                            input logic [FA_BITS-1:0] a);
    rast_beat_t b;
    b.mode = m;
    b.cx = cx;
    b.cy = cy;
    b.a = a;
    pending_beats.push_back(b);
    beats_queued++;
    if (m != MODE_STEP)
      starts_queued++;
  endtask

  task automatic queue_steps(input int n);
    repeat (n) queue_beat(MODE_STEP, CB'($urandom), CB'($urandom), FA_BITS'($urandom));
  endtask

  task automatic queue_curve(input mode_t kind, input logic [CB-1:0] cx,
                             input logic [CB-1:0] cy, input logic [FA_BITS-1:0] a,
                             input int steps);
    queue_beat(kind, cx, cy, a);
    queue_steps(steps);
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || s_tvalid || expected_points.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_dims(input int w, input int h);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data <= DIM_BITS'(w);
    @(negedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data <= DIM_BITS'(h);
    @(negedge clk);
    cfg_we <= 1'b0;
    width_reg = w;
    height_reg = h;
  endtask

  task automatic random_curves(input int budget);
    int first, r, a, steps;
    first = beats_queued;
    while (beats_queued - first < budget) begin
      r = $urandom_range(99);
      if (r < 85) begin
        r = $urandom_range(99);
        a = (r < 70) ? $urandom_range(0, 24) :
            (r < 90) ? $urandom_range(25, 400) : $urandom_range(401, 4095);
        steps = ($urandom_range(99) < 90) ? $urandom_range(0, 40) : $urandom_range(41, 300);
        queue_curve(mode_t'($urandom_range(2)), CB'($urandom), CB'($urandom),
                    FA_BITS'(a), steps);
      end else if (r < 93) begin
        queue_steps(1);
      end else begin
        queue_beat(mode_t'($urandom_range(2)), CB'($urandom), CB'($urandom),
                   FA_BITS'($urandom));
      end
    end
  endtask

  task automatic run_phase(input int w, input int h, input int send_pct, input int recv_pct,
                           input int budget, input bit squeeze);
    write_dims(w, h);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    random_curves(budget);
    if (squeeze)
      hold_req = 1'b1;
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 19;
    recv_idle_pct = 62;

    // directed, reset dimensions
    queue_steps(1);
    queue_curve(MODE_MID, 16'h7fff, 16'h8000, 12'd0, 2);
    queue_curve(MODE_UP, 16'h8000, 16'h7fff, 12'd1, 3);
    queue_curve(MODE_DOWN, 16'hffff, 16'h0000, 12'hfff, 2);
    queue_curve(MODE_MID, 16'h0000, 16'hffff, 12'hfff, 2);
    queue_curve(MODE_UP, 16'd100, -16'sd100, 12'd3, 2);
    queue_curve(MODE_DOWN, -16'sd7, 16'd50, 12'd2, 4);
    wait_idle();

    // zero width and height end region 2 at once
    write_dims(0, 0);
    queue_curve(MODE_UP, 16'd5, 16'd5, 12'd1, 3);
    queue_curve(MODE_DOWN, 16'd5, 16'd5, 12'd2, 3);
    wait_idle();

    run_phase(16, 12, 19, 62, 300, 1'b0);
    run_phase(4096, 4096, 19, 62, 300, 1'b1);
    run_phase(1, 1, 62, 19, 300, 1'b0);
    run_phase(40, 4096, 62, 19, 300, 1'b0);
    run_phase(4096, 25, 0, 0, 300, 1'b0);
    run_phase(200, 150, 0, 0, 300, 1'b0);

    // downward walk with A zero stays on the vertex column
    queue_curve(MODE_DOWN, 16'h8000, 16'h8000, 12'd0, 40);
    wait_idle();
    repeat (10) @(negedge clk);

    if (expected_points.size() != 0)
      report_mismatch("points never delivered", 0, expected_points.size());
    $display("%0d beats sent (%0d curve starts), %0d results checked", beats_queued,
             starts_queued, points_checked);
    $display("%0d point pairs drawn, %0d finished results, %0d mismatches", pairs_seen,
             ends_seen, error_count);
    if (error_count == 0)
      $display("parabola_rasterizer_unit_tb: clean");
    else
      $display("parabola_rasterizer_unit_tb: errors");
    $finish;
  end

endmodule
